### hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define GYFP_ASSERT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, switched off while reset is high.
`define GYFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/gyfp_pkg.sv
package gyfp_pkg;

  // Field widths of the byte stream and the results.
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 16;
  localparam int YAW_W     = 10;
  localparam int HEAD_W    = 9;
  localparam int OFFSET_W  = 9;
  localparam int DIFF_W    = 11;

  // Frame layout.
  localparam int FRAME_BYTES_DEF = 7;
  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hAA;
  localparam logic [WORD_W-1:0] YAW_MIDPOINT = 16'd32768;

  // Division by 100 as a multiply by ceil(2^23 / 100) and a shift of 23.
  // The error stays below 0.01 for every 16-bit dividend, so the floor is exact.
  localparam int DIV_MULT_W = 17;
  localparam int PROD_W     = WORD_W + DIV_MULT_W;
  localparam int DIV_SHIFT  = 23;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 17'd83887;
  localparam int QUOT_W     = 9;

  // Heading wrap limits.
  localparam logic signed [DIFF_W-1:0] HEAD_MAX  = 11'sd180;
  localparam logic signed [DIFF_W-1:0] HEAD_MIN  = -11'sd180;
  localparam logic signed [DIFF_W-1:0] FULL_TURN = 11'sd360;

  // Request held between the frame stage and the heading stage.
  typedef struct packed {
    logic              valid;
    logic              done;
    logic              positive;
    logic [QUOT_W-1:0] quot;
  } gyfp_stage_t;

endpackage

### hdl/gyro_yaw_frame_parser.sv
// Gyro yaw frame parser. Takes one serial byte per request and returns one
// result per byte, carrying the latest yaw in whole degrees, the heading
// (yaw minus cfg offset, wrapped once towards plus or minus 180) and a flag that
// marks the byte which closed a frame. A frame opens with 0xAA and is
// FRAME_BYTES long; bytes 1 and 2 form the big-endian yaw word. The block
// sustains one byte per clock cycle while results are taken at the output.
// Each byte passes the stage register, after the frame counter and the
// reciprocal multiply that divides by 100, and then the result register,
// after the sign, offset subtraction and wrap. There is no clearing pass
// after reset. The offset register is written through cfg_wr_en and
// cfg_wr_data and should only change while the block is idle.
module gyro_yaw_frame_parser #(
  parameter int FRAME_BYTES = gyfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic signed [gyfp_pkg::OFFSET_W-1:0] cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [gyfp_pkg::BYTE_W-1:0]          rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [gyfp_pkg::YAW_W-1:0]    yaw_degrees,
  output logic signed [gyfp_pkg::HEAD_W-1:0]   heading,
  output logic                                 frame_done
);
  import gyfp_pkg::*;

  logic signed [OFFSET_W-1:0] heading_offset;
  gyfp_stage_t                stage;
  logic                       advance;

  // Calibration offset register.
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_offset <= '0;
    end else if (cfg_wr_en) begin
      heading_offset <= cfg_wr_data;
    end
  end

  gyfp_frame #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .stage    (stage)
  );

  gyfp_heading u_heading (
    .clk            (clk),
    .rst            (rst),
    .stage          (stage),
    .advance        (advance),
    .heading_offset (heading_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .yaw_degrees    (yaw_degrees),
    .heading        (heading),
    .frame_done     (frame_done)
  );

endmodule

### hdl/gyfp_frame.sv
module gyfp_frame #(
  parameter int FRAME_BYTES = gyfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gyfp_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                          advance,
  output gyfp_pkg::gyfp_stage_t         stage
);
  import gyfp_pkg::*;

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_IDLE = '0;
  localparam logic [POS_W-1:0] POS_HIGH = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LOW  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0]      frame_position;
  logic [POS_W-1:0]      frame_position_next;
  logic [BYTE_W-1:0]     yaw_high_byte;
  logic [BYTE_W-1:0]     yaw_low_byte;
  logic                  accept;
  logic                  done_next;
  logic [WORD_W-1:0]     word;
  logic                  positive;
  logic [WORD_W-1:0]     operand;
  logic [PROD_W-1:0]     product;

  // The stage takes a new request when it is empty or its content moves on.
  assign in_ready = !stage.valid || advance;
  assign accept   = in_valid && in_ready;

  // Frame position tracking.
  always_comb begin
    frame_position_next = frame_position;
    done_next           = 1'b0;
    if (frame_position == POS_IDLE) begin
      if (rx_byte == HEADER_BYTE) begin
        frame_position_next = POS_HIGH;
      end
    end else if (frame_position == POS_LAST) begin
      frame_position_next = POS_IDLE;
      done_next           = 1'b1;
    end else begin
      frame_position_next = frame_position + POS_W'(1);
    end
  end

  // The low yaw byte may arrive on the very byte that closes a short frame.
  assign word = {yaw_high_byte, (frame_position == POS_LOW) ? rx_byte : yaw_low_byte};

  // Words above the midpoint decode to (65535 - T) / 100, the rest to T / 100
  // with the sign flipped later; 65535 - T is the bitwise inverse of T.
  assign positive = word > YAW_MIDPOINT;
  assign operand  = positive ? ~word : word;
  assign product  = PROD_W'(operand) * PROD_W'(DIV_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= POS_IDLE;
    end else if (accept) begin
      frame_position <= frame_position_next;
    end
  end

  // Yaw bytes are captured at their places in the frame.
  always_ff @(posedge clk) begin
    if (accept && frame_position == POS_HIGH) begin
      yaw_high_byte <= rx_byte;
    end
    if (accept && frame_position == POS_LOW) begin
      yaw_low_byte <= rx_byte;
    end
  end

  // Stage register holding the quotient for the heading stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (in_ready) begin
      stage.valid <= in_valid;
    end
    if (accept) begin
      stage.done     <= done_next;
      stage.positive <= positive;
      stage.quot     <= product[DIV_SHIFT +: QUOT_W];
    end
  end

endmodule

### hdl/gyfp_heading.sv
module gyfp_heading (
  input  logic                                clk,
  input  logic                                rst,
  input  gyfp_pkg::gyfp_stage_t               stage,
  output logic                                advance,
  input  logic signed [gyfp_pkg::OFFSET_W-1:0] heading_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gyfp_pkg::YAW_W-1:0]   yaw_degrees,
  output logic signed [gyfp_pkg::HEAD_W-1:0]  heading,
  output logic                                frame_done
);
  import gyfp_pkg::*;

  logic signed [YAW_W-1:0]  yaw_value;
  logic signed [YAW_W-1:0]  yaw_value_next;
  logic signed [YAW_W-1:0]  quot_ext;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] wrapped;
  logic                     take;

  // The result register frees up when it is empty or being read.
  assign advance = !out_valid || out_ready;
  assign take    = stage.valid && advance;

  // Yaw update on a completed frame.
  assign quot_ext       = $signed(YAW_W'(stage.quot));
  assign yaw_value_next = !stage.done ? yaw_value :
                          stage.positive ? quot_ext : -quot_ext;

  // Heading is yaw minus offset, folded back by one full turn at most.
  assign diff = DIFF_W'(yaw_value_next) - DIFF_W'(heading_offset);

  always_comb begin
    wrapped = diff;
    if (diff > HEAD_MAX) begin
      wrapped = diff - FULL_TURN;
    end else if (diff < HEAD_MIN) begin
      wrapped = diff + FULL_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_value <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        yaw_value <= yaw_value_next;
      end
      if (advance) begin
        out_valid <= stage.valid;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (take) begin
      yaw_degrees <= yaw_value_next;
      heading     <= wrapped[HEAD_W-1:0];
      frame_done  <= stage.done;
    end
  end

endmodule

### hdl/gyfp_checker.sv
`include "assert_macros.svh"

module gyfp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [gyfp_pkg::YAW_W-1:0]   yaw_degrees,
  input logic signed [gyfp_pkg::HEAD_W-1:0]  heading,
  input logic                                frame_done
);

  // A result that is not taken keeps its value.
  `GYFP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(yaw_degrees) && $stable(heading) && $stable(frame_done))

  // The input side only stalls while a result waits at the output.
  `GYFP_ASSERT(a_stall_cause, clk, rst, !in_ready, out_valid)

  // An accepted byte is followed at the output, after the stage and result registers, by its result or an older one.
  `GYFP_ASSERT_NEXT(a_result_soon, clk, rst, in_valid && in_ready, ##1 out_valid)

  // Decoded yaw never leaves the range the divide by 100 allows.
  `GYFP_ASSERT(a_yaw_range, clk, rst, out_valid, yaw_degrees >= -327 && yaw_degrees <= 327)

endmodule

bind gyro_yaw_frame_parser gyfp_checker u_gyfp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .yaw_degrees (yaw_degrees),
  .heading     (heading),
  .frame_done  (frame_done)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gyfp_pkg::*;

  localparam int FRAME_LEN = FRAME_BYTES_DEF;
  localparam int WORD_MAX  = 65535;
  localparam int DEG_SCALE = 100;
  localparam int HALF_TURN = 180;
  localparam int FULL_REV  = 360;
  localparam int MAX_WAIT  = 17;
  localparam int PHASE_LEN = 90;

  // One result as the block should return it.
  typedef struct packed {
    logic signed [YAW_W-1:0]  yaw;
    logic signed [HEAD_W-1:0] heading;
    logic                     done;
  } yaw_result_t;

  // Tracks the frame position, the yaw bytes and the offset, and keeps the
  // results still owed by the block in request order.
  class yaw_heading_scoreboard;
    int          frame_pos;
    logic [7:0]  yaw_hi;
    logic [7:0]  yaw_lo;
    int          yaw_deg;
    int          offset_deg;
    int          errors;
    int          frames_seen;
    yaw_result_t expected_results[$];

    function new();
      frame_pos   = 0;
      yaw_hi      = '0;
      yaw_lo      = '0;
      yaw_deg     = 0;
      offset_deg  = 0;
      errors      = 0;
      frames_seen = 0;
    endfunction

    function void set_offset(logic signed [OFFSET_W-1:0] value);
      offset_deg = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advances the frame tracking by one accepted byte and queues its result.
    function void note_request(logic [BYTE_W-1:0] rx);
      yaw_result_t res;
      int          word;
      int          hd;
      res.done = 1'b0;
      if (frame_pos == 0) begin
        if (rx == HEADER_BYTE) frame_pos = 1;
      end else begin
        if (frame_pos == 1) yaw_hi = rx;
        else if (frame_pos == 2) yaw_lo = rx;
        frame_pos++;
        if (frame_pos >= FRAME_LEN) begin
          word = {yaw_hi, yaw_lo};
          // The upper half of the word counts down from the top of the range.
          if (word > int'(YAW_MIDPOINT)) yaw_deg = (WORD_MAX - word) / DEG_SCALE;
          else yaw_deg = -(word / DEG_SCALE);
          frame_pos = 0;
          res.done  = 1'b1;
          frames_seen++;
        end
      end
      // The wrap is applied only once, even for offsets beyond half a turn.
      hd = yaw_deg - offset_deg;
      if (hd > HALF_TURN) hd -= FULL_REV;
      else if (hd < -HALF_TURN) hd += FULL_REV;
      res.yaw     = yaw_deg[YAW_W-1:0];
      res.heading = hd[HEAD_W-1:0];
      expected_results.push_back(res);
    endfunction

    // Compares one returned result with the oldest outstanding one.
    function void check_result(logic signed [YAW_W-1:0] yaw,
                               logic signed [HEAD_W-1:0] hd, logic done);
      yaw_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("result returned with no request outstanding: yaw %0d heading %0d",
               yaw, hd);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (yaw !== exp_res.yaw) begin
        $error("yaw_degrees: expected %0d, got %0d", $signed(exp_res.yaw), yaw);
        errors++;
      end
      if (hd !== exp_res.heading) begin
        $error("heading: expected %0d, got %0d", $signed(exp_res.heading), hd);
        errors++;
      end
      if (done !== exp_res.done) begin
        $error("frame_done: expected %0d, got %0d", exp_res.done, done);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic signed [OFFSET_W-1:0] cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [BYTE_W-1:0]          rx_byte = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [YAW_W-1:0]    yaw_degrees;
  logic signed [HEAD_W-1:0]   heading;
  logic                       frame_done;

  yaw_heading_scoreboard sb = new();
  bit quiet = 1'b0;
  int bytes_sent = 0;
  int offsets_applied = 0;

  gyro_yaw_frame_parser #(.FRAME_BYTES(FRAME_LEN)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .yaw_degrees(yaw_degrees),
    .heading    (heading),
    .frame_done (frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Samples both handshakes at the edge; requests are noted before results.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(rx_byte);
      if (out_valid && out_ready) sb.check_result(yaw_degrees, heading, frame_done);
    end
  end

  function automatic int unsigned pick_wait();
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Presents one byte after a random gap and holds it until it is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] value);
    int unsigned gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= value;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Sends a header, the yaw word and random filler up to the frame length.
  task automatic send_frame(input logic [WORD_W-1:0] word);
    int k;
    send_byte(HEADER_BYTE);
    send_byte(word[15:8]);
    send_byte(word[7:0]);
    for (k = 3; k < FRAME_LEN; k++) begin
      if ($urandom_range(0, 7) == 0) send_byte(HEADER_BYTE);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Holds the sender back until every outstanding result has come back.
  // It waits on the clock first so that the last accepted request is surely noted.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_offset(input logic signed [OFFSET_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_offset(value);
    offsets_applied++;
  endtask

  // Picks a yaw word, leaning towards the midpoint and the ends of the range.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return YAW_MIDPOINT - 1 + WORD_W'($urandom_range(0, 2));
      1: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return '1;
          2: return 16'(DEG_SCALE - 1);
          3: return 16'(DEG_SCALE);
          default: return 16'(WORD_MAX - DEG_SCALE);
        endcase
      end
      default: return WORD_W'($urandom_range(0, WORD_MAX));
    endcase
  endfunction

  // The result side stalls for a random number of cycles before each result unless quiet is set.
  initial begin
    int unsigned stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic signed [OFFSET_W-1:0] offset_list[7];
    int p;
    int k;
    int phase_start;
    offset_list = '{9'sd180, -9'sd180, 9'sd255, -9'sd256, 9'sd0, 9'sd97, -9'sd45};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: stray bytes while idle, the midpoint word and the word
    // above it, and a frame made wholly of header values.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(YAW_MIDPOINT);
    send_frame(YAW_MIDPOINT + 1);
    for (k = 0; k < FRAME_LEN; k++) send_byte(HEADER_BYTE);

    // Random part: one phase per offset, mostly whole frames with some noise.
    for (p = 0; p < 7; p++) begin
      write_offset(offset_list[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_LEN) begin
        if ($urandom_range(0, 15) == 0) quiet = !quiet;
        if ($urandom_range(0, 4) != 0) begin
          send_frame(pick_word());
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes, %0d of them closing a frame, under %0d offset settings.",
             bytes_sent, sb.frames_seen, offsets_applied);
    $display("Offsets ranged over both ends of the register, with stalls on both sides.");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
